FILE: rtl/core/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// shared constants for the vector normaliser
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int NUM_LANES  = 4;
   localparam int UNIT_WIDTH = 18;
   localparam int DIM_WIDTH  = 3;
   localparam int THR_WIDTH  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // dimension codes
   localparam logic [DIM_WIDTH-1:0] DIM_THREE = 3'd3;
   localparam logic [DIM_WIDTH-1:0] DIM_FOUR  = 3'd4;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] REG_ZERO_THRESHOLD = 2'd0;

endpackage

FILE: rtl/core/vn_req_if.sv
// ----------------------------------------------------------------------------
// vn_req_if
// input item channel: one vector per item
// ----------------------------------------------------------------------------
interface vn_req_if #(parameter int COMPONENT_WIDTH = 32);
   logic                              valid;
   logic                              ready;
   logic [2:0]                        dimension;
   logic signed [COMPONENT_WIDTH-1:0] comp_x;
   logic signed [COMPONENT_WIDTH-1:0] comp_y;
   logic signed [COMPONENT_WIDTH-1:0] comp_z;
   logic signed [COMPONENT_WIDTH-1:0] comp_w;

   modport source (output valid, dimension, comp_x, comp_y, comp_z, comp_w, input ready);
   modport sink   (input valid, dimension, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

FILE: rtl/core/vn_rsp_if.sv
// ----------------------------------------------------------------------------
// vn_rsp_if
// result item channel: one unit vector per item
// ----------------------------------------------------------------------------
interface vn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] unit_x;
   logic signed [17:0] unit_y;
   logic signed [17:0] unit_z;
   logic signed [17:0] unit_w;
   logic               zero_length;

   modport source (output valid, unit_x, unit_y, unit_z, unit_w, zero_length, input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, zero_length, output ready);
endinterface

FILE: rtl/core/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// pipelined integer square root, one root bit per stage, with side payload
// ----------------------------------------------------------------------------
module vn_sqrt #(
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 132
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_sum,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int SUM_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CMP_W = ROOT_W + 4;

   logic              v_ff    [ROOT_W];
   logic [SUM_W-1:0]  s_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              v_src;
      logic [SUM_W-1:0]  s_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SIDE_W-1:0] side_src;
      logic [CMP_W-1:0]  cat;
      logic [CMP_W-1:0]  trial;
      logic              take;
      logic [CMP_W-1:0]  diff;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign s_src    = in_sum;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign s_src    = s_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      // bring down the next two bits, try root*4+1
      always_comb begin
         cat   = {rem_src, s_src[SUM_W-1 -: 2]};
         trial = {2'b00, root_src, 2'b01};
         take  = (cat >= trial);
         diff  = cat - trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
         if (en) begin
            s_ff[i]    <= {s_src[SUM_W-3:0], 2'b00};
            rem_ff[i]  <= take ? diff[REM_W-1:0] : cat[REM_W-1:0];
            root_ff[i] <= {root_src[ROOT_W-2:0], take};
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule

FILE: rtl/core/vn_div_lane.sv
// ----------------------------------------------------------------------------
// vn_div_lane
// one lane: pipelined restoring divide, mag * 2^FRAC / len, one bit per stage
// ----------------------------------------------------------------------------
module vn_div_lane #(
   parameter int MAG_W = 32,
   parameter int LEN_W = 33,
   parameter int FRAC  = 16
) (
   input  logic            clock,
   input  logic            en,
   input  logic [MAG_W-1:0] mag,
   input  logic [LEN_W-1:0] len,
   output logic [FRAC:0]   quot
);
   localparam int STAGES = FRAC + 1;
   localparam int R_W    = LEN_W + 1;

   logic [R_W-1:0]   r_ff   [STAGES];
   logic [LEN_W-1:0] len_ff [STAGES];
   logic [FRAC:0]    q_ff   [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [R_W-1:0]   r_src;
      logic [LEN_W-1:0] d_src;
      logic [FRAC:0]    q_src;
      logic             take;

      if (j == 0) begin : g_first
         assign r_src = R_W'(mag);
         assign d_src = len;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = {r_ff[j-1][R_W-2:0], 1'b0};
         assign d_src = len_ff[j-1];
         assign q_src = q_ff[j-1];
      end

      assign take = (r_src >= R_W'(d_src));

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]   <= take ? r_src - R_W'(d_src) : r_src;
            len_ff[j] <= d_src;
            q_ff[j]   <= {q_src[FRAC-1:0], take};
         end
      end
   end

   assign quot = q_ff[STAGES-1];
endmodule

FILE: rtl/core/vector_normalizer.sv
// ----------------------------------------------------------------------------
// vector_normalizer
// euclidean normalisation of a 2, 3 or 4 component fixed point vector
// ----------------------------------------------------------------------------
// req carries one vector per item (dimension plus four signed q16.16
// components); rsp returns the signed q1.16 unit vector and a zero_length
// flag. both are valid/ready channels, an item moves when both are high.
// the csr port (apb style, always ready) holds zero_threshold at address 0;
// write it only while no item is in flight.
// one item is accepted every cycle while req.ready is high. the result
// reaches rsp through 54 register stages: three front stages (magnitude,
// square, sum), COMPONENT_WIDTH + 1 stages of the square root pipeline (one
// per root bit), RESULT_FRACTION_BITS + 1 stages in each divider lane (one
// per quotient bit) and the output register.
// the whole pipeline moves together: when rsp holds a result that is not
// taken, req.ready drops and every stage holds; a bubble in the output
// register lets the pipeline advance regardless.
// synchronous reset clears all valid bits and the threshold register.
// ----------------------------------------------------------------------------
module vector_normalizer #(
   parameter int COMPONENT_WIDTH      = 32,
   parameter int RESULT_FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   vn_req_if.sink                       req,
   vn_rsp_if.source                     rsp,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                         csr_pready
);
   import vn_pkg::*;

   localparam int CW     = COMPONENT_WIDTH;
   localparam int FRAC   = RESULT_FRACTION_BITS;
   localparam int ROOT_W = CW + 1;
   localparam int SUM_W  = 2 * ROOT_W;
   localparam int SQ_W   = 2 * CW;
   localparam int SIDE_W = NUM_LANES * (CW + 1);
   localparam int DSTG   = FRAC + 1;
   localparam int QX_W   = FRAC + 1 + UNIT_WIDTH;

   // pipeline advance: output register empty or being taken
   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // configuration register
   logic [THR_WIDTH-1:0] thr_ff;
   logic                 csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == REG_ZERO_THRESHOLD);
   assign csr_prdata = (csr_paddr == REG_ZERO_THRESHOLD) ?
                       CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr) begin
         thr_ff <= csr_pwdata[THR_WIDTH-1:0];
      end
   end

   // stage a: magnitudes and signs, unused lanes forced to zero
   logic [CW-1:0] comp_in [NUM_LANES];
   logic          use_in  [NUM_LANES];
   logic [CW-1:0] mag_a_ff [NUM_LANES];
   logic          neg_a_ff [NUM_LANES];
   logic          va_ff;

   assign comp_in[0] = req.comp_x;
   assign comp_in[1] = req.comp_y;
   assign comp_in[2] = req.comp_z;
   assign comp_in[3] = req.comp_w;
   assign use_in[0]  = 1'b1;
   assign use_in[1]  = 1'b1;
   assign use_in[2]  = (req.dimension >= DIM_THREE);
   assign use_in[3]  = (req.dimension >= DIM_FOUR);

   // stage b: squares
   logic [SQ_W-1:0] sq_b_ff  [NUM_LANES];
   logic [CW-1:0]   mag_b_ff [NUM_LANES];
   logic            neg_b_ff [NUM_LANES];
   logic            vb_ff;

   // stage c: sum of squares
   logic [SUM_W-1:0] sum_c_ff;
   logic [SIDE_W-1:0] side_c_ff;
   logic             vc_ff;

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_front
      logic          neg;
      logic [CW-1:0] mag;
      always_comb begin
         neg = comp_in[k][CW-1] && use_in[k];
         mag = '0;
         if (use_in[k]) begin
            mag = comp_in[k][CW-1] ? (~comp_in[k] + CW'(1)) : comp_in[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mag_a_ff[k] <= mag;
            neg_a_ff[k] <= neg;
            sq_b_ff[k]  <= SQ_W'(mag_a_ff[k]) * SQ_W'(mag_a_ff[k]);
            mag_b_ff[k] <= mag_a_ff[k];
            neg_b_ff[k] <= neg_a_ff[k];
            side_c_ff[k*(CW+1) +: CW+1] <= {neg_b_ff[k], mag_b_ff[k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      if (en) begin
         sum_c_ff <= SUM_W'(sq_b_ff[0]) + SUM_W'(sq_b_ff[1])
                   + SUM_W'(sq_b_ff[2]) + SUM_W'(sq_b_ff[3]);
      end
   end

   // square root pipeline
   logic              vr;
   logic [ROOT_W-1:0] root;
   logic [SIDE_W-1:0] side_r;

   vn_sqrt #(.ROOT_W(ROOT_W), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff),
      .in_sum    (sum_c_ff),
      .in_side   (side_c_ff),
      .out_valid (vr),
      .out_root  (root),
      .out_side  (side_r)
   );

   // zero-length test, travels with the divider lanes
   logic zero_r;
   assign zero_r = (root <= ROOT_W'(thr_ff));

   logic                 dv_ff [DSTG];
   logic                 dz_ff [DSTG];
   logic [NUM_LANES-1:0] dn_ff [DSTG];
   logic [NUM_LANES-1:0] neg_r;
   logic [FRAC:0]        quot [NUM_LANES];

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      assign neg_r[k] = side_r[k*(CW+1) + CW];
      vn_div_lane #(.MAG_W(CW), .LEN_W(ROOT_W), .FRAC(FRAC)) u_div (
         .clock (clock),
         .en    (en),
         .mag   (side_r[k*(CW+1) +: CW]),
         .len   (root),
         .quot  (quot[k])
      );
   end

   for (genvar j = 0; j < DSTG; j++) begin : g_flag
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= (j == 0) ? vr : dv_ff[(j == 0) ? 0 : j-1];
         end
         if (en) begin
            dz_ff[j] <= (j == 0) ? zero_r : dz_ff[(j == 0) ? 0 : j-1];
            dn_ff[j] <= (j == 0) ? neg_r  : dn_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // merge: apply signs, mask to the unit width, clear on zero length
   logic signed [UNIT_WIDTH-1:0] unit_in [NUM_LANES];
   logic signed [UNIT_WIDTH-1:0] unit_ff [NUM_LANES];
   logic                         zero_ff;
   logic                         rsp_valid_ff;

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_merge
      logic [QX_W-1:0]       qx;
      logic [UNIT_WIDTH-1:0] qm;
      always_comb begin
         qx = QX_W'(quot[k]);
         qm = qx[UNIT_WIDTH-1:0];
         if (dz_ff[DSTG-1]) begin
            unit_in[k] = '0;
         end else if (dn_ff[DSTG-1][k]) begin
            unit_in[k] = -qm;
         end else begin
            unit_in[k] = qm;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            unit_ff[k] <= unit_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[DSTG-1];
      end
      if (en) begin
         zero_ff <= dz_ff[DSTG-1];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.unit_x      = unit_ff[0];
   assign rsp.unit_y      = unit_ff[1];
   assign rsp.unit_z      = unit_ff[2];
   assign rsp.unit_w      = unit_ff[3];
   assign rsp.zero_length = zero_ff;
endmodule
